FILE: rtl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM master package
// Shared types, codes and sequence tables of the tick-driven EEPROM master.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned SEG_W      = 3;
    localparam int unsigned STEP_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_WAIT_TICKS = 1'd1;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd80;
    localparam logic [15:0] WRITE_WAIT_RST     = 16'd500;

    localparam logic [SEG_W-1:0] READ_LAST_SEG  = 3'd6;
    localparam logic [SEG_W-1:0] WRITE_LAST_SEG = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_READ,
        MODE_WRITE,
        MODE_WAIT
    } t_mode;

    typedef enum logic [1:0] {
        SEG_START,
        SEG_OUT,
        SEG_IN,
        SEG_STOP
    } t_seg_kind;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_CTRL_W,
        SRC_ADDR,
        SRC_DATA,
        SRC_CTRL_R
    } t_src;

    typedef struct packed {
        t_seg_kind         kind;
        logic [STEP_W-1:0] step;
        logic [1:0]        phase;
    } t_pin_ctl;

    function automatic logic [STEP_W-1:0] seg_len(input t_seg_kind kind);
        case (kind)
            SEG_START: seg_len = 5'd5;
            SEG_OUT:   seg_len = 5'd27;
            SEG_IN:    seg_len = 5'd21;
            default:   seg_len = 5'd4;
        endcase
    endfunction

    function automatic t_seg_kind seg_kind(input logic is_read, input logic [SEG_W-1:0] seg);
        if (is_read) begin
            case (seg)
                3'd0, 3'd3:       seg_kind = SEG_START;
                3'd1, 3'd2, 3'd4: seg_kind = SEG_OUT;
                3'd5:             seg_kind = SEG_IN;
                default:          seg_kind = SEG_STOP;
            endcase
        end else begin
            case (seg)
                3'd0:             seg_kind = SEG_START;
                3'd1, 3'd2, 3'd3: seg_kind = SEG_OUT;
                default:          seg_kind = SEG_STOP;
            endcase
        end
    endfunction

    function automatic t_src seg_src(input logic is_read, input logic [SEG_W-1:0] seg);
        case (seg)
            3'd1:    seg_src = SRC_CTRL_W;
            3'd2:    seg_src = SRC_ADDR;
            3'd3:    seg_src = is_read ? SRC_NONE : SRC_DATA;
            3'd4:    seg_src = is_read ? SRC_CTRL_R : SRC_NONE;
            default: seg_src = SRC_NONE;
        endcase
    endfunction

endpackage

FILE: rtl/i2cee_in_if.sv
// ----------------------------------------------------------------------------
// I2C EEPROM master tick channel
// Valid/ready channel that carries one pin-update tick and its command.
// ----------------------------------------------------------------------------
interface i2cee_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] mem_address;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, func, mem_address, write_data, sda_in, input ready);
    modport sink   (input valid, func, mem_address, write_data, sda_in, output ready);
endinterface

FILE: rtl/i2cee_out_if.sv
// ----------------------------------------------------------------------------
// I2C EEPROM master result channel
// Valid/ready channel that carries the pin levels and status of one tick.
// ----------------------------------------------------------------------------
interface i2cee_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       rejected;

    modport source  (output valid, scl_out, sda_out, busy_res, done_res, read_byte, rejected,
                     input ready);
    modport sink    (input valid, scl_out, sda_out, busy_res, done_res, read_byte, rejected,
                     output ready);
    modport monitor (input valid, ready, scl_out, sda_out, busy_res, done_res, read_byte,
                     rejected);
endinterface

FILE: rtl/i2cee_pin_step.sv
// ----------------------------------------------------------------------------
// I2C EEPROM master pin step
// Decodes one step of a bus segment into new SCL, SDA and shift register values.
// ----------------------------------------------------------------------------
module i2cee_pin_step (
    input  i2cee_pkg::t_pin_ctl i_ctl,
    input  logic [7:0]          i_src_byte,
    input  logic [7:0]          i_shift,
    input  logic                i_scl,
    input  logic                i_sda,
    input  logic                i_sda_in,
    output logic [7:0]          o_shift,
    output logic                o_scl,
    output logic                o_sda
);

    logic [7:0] w_byte;

    always_comb begin
        o_shift = i_shift;
        o_scl   = i_scl;
        o_sda   = i_sda;
        w_byte  = (i_ctl.step == 5'd0) ? i_src_byte : i_shift;
        case (i_ctl.kind)
            i2cee_pkg::SEG_START: begin
                case (i_ctl.step)
                    5'd1:    o_sda = 1'b1;
                    5'd2:    o_scl = 1'b1;
                    5'd3:    o_sda = 1'b0;
                    default: o_scl = 1'b0;
                endcase
            end
            i2cee_pkg::SEG_OUT: begin
                if (i_ctl.step < 5'd24) begin
                    case (i_ctl.phase)
                        2'd0: begin
                            o_shift = w_byte;
                            o_sda   = w_byte[7];
                        end
                        2'd1: o_scl = 1'b1;
                        default: begin
                            o_scl   = 1'b0;
                            o_shift = {i_shift[6:0], 1'b0};
                        end
                    endcase
                end else if (i_ctl.step == 5'd24) begin
                    o_sda = 1'b1;
                end else if (i_ctl.step == 5'd25) begin
                    o_scl = 1'b1;
                end else begin
                    o_scl = 1'b0;
                end
            end
            i2cee_pkg::SEG_IN: begin
                if (i_ctl.step == 5'd0) begin
                    o_sda   = 1'b1;
                    o_shift = 8'd0;
                end else if (i_ctl.step <= 5'd16) begin
                    if (i_ctl.step[0]) begin
                        o_scl = 1'b1;
                    end else begin
                        o_shift = {i_shift[6:0], i_sda_in};
                        o_scl   = 1'b0;
                    end
                end else if (i_ctl.step == 5'd18) begin
                    o_scl = 1'b1;
                end else if (i_ctl.step == 5'd19) begin
                    o_scl = 1'b0;
                end else begin
                    o_sda = 1'b1;
                end
            end
            default: begin
                case (i_ctl.step)
                    5'd0:    o_scl = 1'b0;
                    5'd1:    o_sda = 1'b0;
                    5'd2:    o_scl = 1'b1;
                    default: o_sda = 1'b1;
                endcase
            end
        endcase
    end

endmodule

FILE: rtl/i2c_eeprom_bitbang_master.sv
// ----------------------------------------------------------------------------
// I2C EEPROM bit-bang master
// Tick-driven I2C master for random reads and byte writes to a 24xx EEPROM.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents
// i_in     in   func, mem_address, write_data, sda_in
// o_out    out  scl_out, sda_out, busy_res, done_res, read_byte, rejected
// cfg      in   i_cfg_we, i_cfg_index, i_cfg_data (device_address, write_wait_ticks)
//
// One tick is accepted per clock cycle unless the output stalls; each tick yields
// one result beat in the output register on the next cycle. The sequencer state
// is updated in the cycle of acceptance, so throughput is set by the single output
// register stage. A stalled output holds its beat and the input accepts again once
// it drains. Reset returns the bus to both lines released and the sequencer to idle.
// ----------------------------------------------------------------------------
module i2c_eeprom_bitbang_master (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    i2cee_in_if.sink                            i_in,
    i2cee_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [i2cee_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [i2cee_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    i2cee_pkg::t_mode                   r_mode, n_mode, w_mode;
    logic [i2cee_pkg::SEG_W-1:0]        r_seg, n_seg, w_seg;
    logic [i2cee_pkg::STEP_W-1:0]       r_step, n_step, w_step;
    logic [1:0]                         r_phase, n_phase, w_phase;
    logic [7:0]                         r_shift, n_shift;
    logic                               r_scl, n_scl;
    logic                               r_sda, n_sda;
    logic [15:0]                        r_wait, n_wait;
    logic [7:0]                         r_addr, n_addr;
    logic [7:0]                         r_data, n_data;
    logic [6:0]                         r_dev_addr;
    logic [15:0]                        r_wait_ticks;

    logic                               r_ovalid;
    logic                               r_oscl, r_osda, r_obusy, r_odone, r_orej;
    logic [7:0]                         r_obyte;

    logic                               w_accept, w_cmd, w_is_read, w_last;
    logic                               w_done, w_rej;
    logic [7:0]                         w_rd, w_src_byte, w_pin_shift;
    logic                               w_pin_scl, w_pin_sda;
    i2cee_pkg::t_pin_ctl                w_ctl;

    assign i_in.ready = !r_ovalid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_cmd      = (i_in.func == i2cee_pkg::FUNC_READ) || (i_in.func == i2cee_pkg::FUNC_WRITE);

    always_comb begin
        w_mode  = r_mode;
        w_seg   = r_seg;
        w_step  = r_step;
        w_phase = r_phase;
        n_addr  = r_addr;
        n_data  = r_data;
        w_rej   = 1'b0;
        if (r_mode == i2cee_pkg::MODE_IDLE) begin
            if (w_cmd) begin
                w_mode  = (i_in.func == i2cee_pkg::FUNC_READ) ? i2cee_pkg::MODE_READ
                                                              : i2cee_pkg::MODE_WRITE;
                w_seg   = '0;
                w_step  = '0;
                w_phase = '0;
                n_addr  = i_in.mem_address;
                if (i_in.func == i2cee_pkg::FUNC_WRITE) begin
                    n_data = i_in.write_data;
                end
            end
        end else if (w_cmd) begin
            w_rej = 1'b1;
        end
    end

    assign w_is_read   = (w_mode == i2cee_pkg::MODE_READ);
    assign w_ctl.kind  = i2cee_pkg::seg_kind(w_is_read, w_seg);
    assign w_ctl.step  = w_step;
    assign w_ctl.phase = w_phase;
    assign w_last      = (w_step == i2cee_pkg::seg_len(w_ctl.kind) - 5'd1) &&
                         (w_seg == (w_is_read ? i2cee_pkg::READ_LAST_SEG
                                              : i2cee_pkg::WRITE_LAST_SEG));

    always_comb begin
        case (i2cee_pkg::seg_src(w_is_read, w_seg))
            i2cee_pkg::SRC_CTRL_W: w_src_byte = {r_dev_addr, 1'b0};
            i2cee_pkg::SRC_CTRL_R: w_src_byte = {r_dev_addr, 1'b1};
            i2cee_pkg::SRC_ADDR:   w_src_byte = n_addr;
            i2cee_pkg::SRC_DATA:   w_src_byte = n_data;
            default:               w_src_byte = 8'd0;
        endcase
    end

    i2cee_pin_step u_pin_step (
        .i_ctl      (w_ctl),
        .i_src_byte (w_src_byte),
        .i_shift    (r_shift),
        .i_scl      (r_scl),
        .i_sda      (r_sda),
        .i_sda_in   (i_in.sda_in),
        .o_shift    (w_pin_shift),
        .o_scl      (w_pin_scl),
        .o_sda      (w_pin_sda)
    );

    always_comb begin
        n_mode  = w_mode;
        n_seg   = w_seg;
        n_step  = w_step;
        n_phase = w_phase;
        n_shift = r_shift;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_wait  = r_wait;
        w_done  = 1'b0;
        w_rd    = 8'd0;
        case (w_mode)
            i2cee_pkg::MODE_READ, i2cee_pkg::MODE_WRITE: begin
                n_shift = w_pin_shift;
                n_scl   = w_pin_scl;
                n_sda   = w_pin_sda;
                if (w_step == i2cee_pkg::seg_len(w_ctl.kind) - 5'd1) begin
                    n_seg   = w_seg + 3'd1;
                    n_step  = '0;
                    n_phase = '0;
                end else begin
                    n_step  = w_step + 5'd1;
                    n_phase = (w_phase == 2'd2) ? 2'd0 : w_phase + 2'd1;
                end
                if (w_last) begin
                    n_seg = '0;
                    if (w_is_read) begin
                        n_mode = i2cee_pkg::MODE_IDLE;
                        w_done = 1'b1;
                        w_rd   = w_pin_shift;
                    end else if (r_wait_ticks == 16'd0) begin
                        n_mode = i2cee_pkg::MODE_IDLE;
                        w_done = 1'b1;
                    end else begin
                        n_mode = i2cee_pkg::MODE_WAIT;
                        n_wait = r_wait_ticks;
                    end
                end
            end
            i2cee_pkg::MODE_WAIT: begin
                n_wait = r_wait - 16'd1;
                if (n_wait == 16'd0) begin
                    n_mode = i2cee_pkg::MODE_IDLE;
                    w_done = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= i2cee_pkg::MODE_IDLE;
            r_seg   <= '0;
            r_step  <= '0;
            r_phase <= '0;
            r_shift <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_wait  <= '0;
            r_addr  <= '0;
            r_data  <= '0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_seg   <= n_seg;
            r_step  <= n_step;
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_wait  <= n_wait;
            r_addr  <= n_addr;
            r_data  <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= i2cee_pkg::DEVICE_ADDRESS_RST;
            r_wait_ticks <= i2cee_pkg::WRITE_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cee_pkg::CFG_DEVICE_ADDRESS:   r_dev_addr   <= i_cfg_data[6:0];
                i2cee_pkg::CFG_WRITE_WAIT_TICKS: r_wait_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_accept) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_oscl  <= n_scl;
            r_osda  <= n_sda;
            r_obusy <= (n_mode != i2cee_pkg::MODE_IDLE);
            r_odone <= w_done;
            r_obyte <= w_rd;
            r_orej  <= w_rej;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.scl_out   = r_oscl;
    assign o_out.sda_out   = r_osda;
    assign o_out.busy_res  = r_obusy;
    assign o_out.done_res  = r_odone;
    assign o_out.read_byte = r_obyte;
    assign o_out.rejected  = r_orej;

endmodule

FILE: rtl/i2cee_checker.sv
// ----------------------------------------------------------------------------
// I2C EEPROM master checker
// Port-level checks on the result beats of the EEPROM master.
// ----------------------------------------------------------------------------
module i2cee_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_scl,
    input logic       i_sda,
    input logic       i_busy,
    input logic       i_done,
    input logic [7:0] i_byte,
    input logic       i_rej
);

    logic w_beat;
    logic r_last_busy;
    logic r_last_scl;
    logic r_last_sda;

    assign w_beat = i_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_busy <= 1'b0;
            r_last_scl  <= 1'b1;
            r_last_sda  <= 1'b1;
        end else if (w_beat) begin
            r_last_busy <= i_busy;
            r_last_scl  <= i_scl;
            r_last_sda  <= i_sda;
        end
    end

    a_one_line_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat |-> (i_scl == r_last_scl) || (i_sda == r_last_sda))
        else $error("SCL and SDA changed on the same beat");

    a_reject_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && i_rej) |-> r_last_busy)
        else $error("Command rejected although the master was idle");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && i_done) |-> (r_last_busy && !i_busy))
        else $error("Done beat without a transaction in progress");

    a_byte_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_done) |-> (i_byte == 8'd0))
        else $error("Read byte is nonzero outside a done beat");

endmodule

bind i2c_eeprom_bitbang_master i2cee_checker u_i2cee_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_scl   (o_out.scl_out),
    .i_sda   (o_out.sda_out),
    .i_busy  (o_out.busy_res),
    .i_done  (o_out.done_res),
    .i_byte  (o_out.read_byte),
    .i_rej   (o_out.rejected)
);
